### hw/rtl/b64e_pkg.sv
// Shared types, constants and the character mapping of the base64 stream encoder.
package b64e_pkg;

	localparam int LINE_CHARS_DEFAULT = 64;
	localparam int JOB_QUEUE_DEPTH = 2;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_PLUS    = 8'h2b;
	localparam logic [7:0] CHAR_SLASH   = 8'h2f;
	localparam logic [7:0] CHAR_PAD     = 8'h3d;
	localparam logic [7:0] CHAR_NL      = 8'h0a;

	// Pad counts of a group.
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// One group of output work: four sextets, how many trailing pads replace
	// sextets, and whether a newline follows the group.
	typedef struct packed {
		logic [3:0][5:0] sextet;
		logic [1:0]      pad_cnt;
		logic            newline;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		begin
			if (v < 6'd26) begin
				c = CHAR_UPPER_A + {2'b00, v};
			end else if (v < 6'd52) begin
				c = CHAR_LOWER_A + {2'b00, v - 6'd26};
			end else if (v < 6'd62) begin
				c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
			end else if (v == 6'd62) begin
				c = CHAR_PLUS;
			end else begin
				c = CHAR_SLASH;
			end
			return c;
		end
	endfunction

endpackage

### hw/rtl/b64e_front.sv
// Front end: gathers bytes into groups, tracks the line grid and issues group jobs.
module b64e_front
	import b64e_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_eom,
	input  logic       wrap_en,
	output logic       job_push,
	output job_t       job_data,
	input  logic       job_full
);

	localparam int GROUP_LIMIT = LINE_CHARS / 4;
	localparam int CNT_W = (GROUP_LIMIT > 1) ? $clog2(GROUP_LIMIT) : 1;

	logic [7:0]       held0_q, held1_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] groups_q;
	logic [CNT_W-1:0] groups_next;
	logic             accept;
	logic             emits;
	logic             full_group;

	assign in_ready   = !job_full;
	assign accept     = in_valid && in_ready;
	assign full_group = (phase_q == 2'd2);
	assign emits      = full_group || in_eom;
	assign job_push   = accept && emits;

	assign groups_next = (groups_q == CNT_W'(GROUP_LIMIT - 1)) ? '0 : groups_q + 1'b1;

	always_comb begin
		job_data = '0;
		case (phase_q)
			2'd2: begin
				job_data.sextet[0] = held0_q[7:2];
				job_data.sextet[1] = {held0_q[1:0], held1_q[7:4]};
				job_data.sextet[2] = {held1_q[3:0], in_byte[7:6]};
				job_data.sextet[3] = in_byte[5:0];
				job_data.pad_cnt   = PAD_NONE;
				job_data.newline   = wrap_en && (in_eom || (groups_next == '0));
			end
			2'd1: begin
				job_data.sextet[0] = held0_q[7:2];
				job_data.sextet[1] = {held0_q[1:0], in_byte[7:4]};
				job_data.sextet[2] = {in_byte[3:0], 2'b00};
				job_data.pad_cnt   = PAD_ONE;
				job_data.newline   = wrap_en;
			end
			default: begin
				job_data.sextet[0] = in_byte[7:2];
				job_data.sextet[1] = {in_byte[1:0], 4'b0000};
				job_data.pad_cnt   = PAD_TWO;
				job_data.newline   = wrap_en;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 2'd0;
			groups_q <= '0;
		end else if (accept) begin
			if (emits) begin
				phase_q <= 2'd0;
			end else if (phase_q == 2'd1) begin
				phase_q <= 2'd2;
			end else begin
				phase_q <= 2'd1;
			end
			if (in_eom) begin
				groups_q <= '0;
			end else if (full_group) begin
				groups_q <= groups_next;
			end
		end
	end

	// Held bytes are payload: they are only read once the phase says they are valid.
	always_ff @(posedge clk) begin
		if (accept && !emits) begin
			if (phase_q == 2'd1) begin
				held1_q <= in_byte;
			end else begin
				held0_q <= in_byte;
			end
		end
	end

endmodule

### hw/rtl/b64e_queue.sv
// Short job queue between the front end and the character emitter.
module b64e_queue
	import b64e_pkg::*;
#(
	parameter int DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/b64e_back.sv
// Back end: turns jobs into characters, one per unstalled cycle, in an output register.
module b64e_back
	import b64e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_empty,
	input  job_t       job_data,
	output logic       job_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	job_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       out_free;
	logic       last_char;
	logic [7:0] next_char;
	logic [2:0] first_pad;

	assign out_free  = !out_valid_q || out_ready;
	assign first_pad = 3'd4 - {1'b0, cur_q.pad_cnt};
	assign last_char = (idx_q == 3'd4) || ((idx_q == 3'd3) && !cur_q.newline);
	assign job_pop   = !job_empty && (!cur_valid_q || (out_free && last_char));

	always_comb begin
		if (idx_q == 3'd4) begin
			next_char = CHAR_NL;
		end else if (idx_q >= first_pad) begin
			next_char = CHAR_PAD;
		end else begin
			next_char = b64_char(cur_q.sextet[idx_q[1:0]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 3'd0;
			end else if (out_free && cur_valid_q) begin
				idx_q <= idx_q + 3'd1;
				if (last_char) begin
					cur_valid_q <= 1'b0;
				end
			end
			if (out_free) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job_data;
		end
		if (out_free && cur_valid_q) begin
			out_char_q <= next_char;
			out_last_q <= last_char;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

### hw/rtl/base64_stream_encoder_top.sv
// Top level of the base64 stream encoder with optional line wrap.
// The encoder takes a message one byte per request on the slave stream, with tlast on the
// message's last byte, and sends base64 characters one per request on the master stream.
// Every three bytes give four characters; a short final group is closed with one or two
// '=' pads. With wrap_enable set, a newline follows every LINE_CHARS/4 groups and one
// newline ends every message. On the master side tlast marks the last character caused
// by one input byte, so bytes that only get held produce no output at all. A byte is
// taken whenever the job queue has room, even while output is stalled. The output side
// moves one character per cycle while the master stream is not stalled and sets the
// sustained rate; a group gives four characters there, or five when a newline follows it.
// With the output idle, the first character of a group reaches the master stream once the
// byte that completes it has been written into the queue, the job has been moved from the
// queue into the emitter and the output register has been loaded. The queue lets the front
// end run up to QUEUE_DEPTH groups ahead. The configuration register is written through
// cfg_we and cfg_wdata; the user must write it only while the encoder is idle, as the
// block itself does not enforce it.
module base64_stream_encoder_top
	import b64e_pkg::*;
#(
	parameter int LINE_CHARS  = LINE_CHARS_DEFAULT,
	parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: wrap_enable.
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	// Slave stream.
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // end_of_message
	// Master stream.
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tlast    // last_of_run
);

	logic wrap_q;
	job_t push_job, pop_job;
	logic push, pop, q_full, q_empty;

	// The only configuration register; the front end samples it with each byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
		end else if (cfg_we) begin
			wrap_q <= cfg_wdata;
		end
	end

	// Front end: holds pending bytes, keeps the line grid and builds one job per group.
	b64e_front #(
		.LINE_CHARS(LINE_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_eom   (s_axis_tlast),
		.wrap_en  (wrap_q),
		.job_push (push),
		.job_data (push_job),
		.job_full (q_full)
	);

	// Group jobs wait here so the byte side and the character side stall independently.
	b64e_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_job),
		.empty     (q_empty)
	);

	// Back end: walks each job one character per cycle, while the output is not stalled, into the output register.
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job_data  (pop_job),
		.job_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### hw/rtl/b64e_checker.sv
// Port-level checks of the base64 stream encoder and their binding to the top level.
module b64e_checker
	import b64e_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       cfg_wdata,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic wrap_q;

	// Mirror of the wrap setting as seen on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
		end else if (cfg_we) begin
			wrap_q <= cfg_wdata;
		end
	end

	// A stalled output request keeps its character and its run marker.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output request changed while stalled");

	// Every character is from the alphabet, a pad or a newline.
	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5a) ||
			(m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h7a) ||
			(m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
			m_axis_tdata == CHAR_PLUS || m_axis_tdata == CHAR_SLASH ||
			m_axis_tdata == CHAR_PAD || m_axis_tdata == CHAR_NL)
		else $error("illegal output character");

	// A newline always closes the run of characters of its byte.
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata == CHAR_NL |-> m_axis_tlast)
		else $error("newline not at end of run");

	// With wrapping off no newline is ever sent.
	a_no_nl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !wrap_q |-> m_axis_tdata != CHAR_NL)
		else $error("newline sent with wrapping off");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (.*);
